// ===== src/rbst_pkg.sv =====
// rbst_pkg: shared types, constants and register indexes of the ray/box slab test
// depends on nothing; imported by every module under src
`timescale 1ns / 1ps
`default_nettype none

package rbst_pkg;

    localparam int COORD_W   = 32;                 // q16.16 coordinate width
    localparam int LIMIT_W   = 31;                 // distance limit width
    localparam int FRAC_W    = 16;                 // fraction bits
    localparam int DIFF_W    = COORD_W + 1;        // bound minus origin, exact
    localparam int NUM_W     = DIFF_W + FRAC_W;    // scaled dividend magnitude
    localparam int DIV_STEPS = COORD_W;            // quotient bits resolved one per stage
    localparam int SH_W      = COORD_W + DIV_STEPS;
    localparam int DIV_LAT   = DIV_STEPS + 2;      // overflow stage + steps + saturate stage
    localparam int AX_LAT    = DIV_LAT + 1;        // operand prep + divider
    localparam int CFG_IDX_W = 3;

    localparam logic signed [COORD_W-1:0] T_POS_INF = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] T_NEG_INF = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic        [LIMIT_W-1:0] dist_limit;
    } rbst_in_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] t_enter;
        logic signed [COORD_W-1:0] t_exit;
    } rbst_out_t;

    // one unsigned division request: |bound - origin| / |dir|, sign of the result
    typedef struct packed {
        logic [DIFF_W-1:0]  mag;
        logic [COORD_W-1:0] den;
        logic               neg;
    } div_op_t;

endpackage

`default_nettype wire

// ===== src/rbst_div.sv =====
// rbst_div: pipelined restoring divider, one quotient bit per stage, saturating result
// depends on rbst_pkg
`timescale 1ns / 1ps
`default_nettype none

module rbst_div import rbst_pkg::*; (
    input  wire                        aclk,
    input  wire                        en,
    input  div_op_t                    op,
    output logic signed [COORD_W-1:0]  quot
);

    logic [NUM_W-1:0]     rem_reg [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg   [0:DIV_STEPS];
    logic [COORD_W-1:0]   den_reg [0:DIV_STEPS];
    logic                 neg_reg [0:DIV_STEPS];
    logic                 ovf_reg [0:DIV_STEPS];
    logic signed [COORD_W-1:0] quot_reg;

    logic [NUM_W-1:0]     rem_next [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] q_next   [0:DIV_STEPS-1];
    logic                 ovf_next;
    logic signed [COORD_W-1:0] quot_next;
    logic [DIV_STEPS-1:0] qmag;
    logic                 big;

    // quotient of 2^32 or more saturates whatever the sign
    assign ovf_next = {{(COORD_W+FRAC_W-DIFF_W){1'b0}}, op.mag} >= {op.den, {FRAC_W{1'b0}}};

    always_comb begin
        logic [SH_W-1:0] ext_rem;
        logic [SH_W-1:0] shifted;
        logic [SH_W-1:0] trial;
        for (int s = 0; s < DIV_STEPS; s++) begin
            ext_rem = {{(SH_W-NUM_W){1'b0}}, rem_reg[s]};
            shifted = {{(SH_W-COORD_W){1'b0}}, den_reg[s]} << (DIV_STEPS - 1 - s);
            trial   = ext_rem - shifted;
            if (ext_rem >= shifted) begin
                rem_next[s] = trial[NUM_W-1:0];
                q_next[s]   = {q_reg[s][DIV_STEPS-2:0], 1'b1};
            end else begin
                rem_next[s] = rem_reg[s];
                q_next[s]   = {q_reg[s][DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    assign qmag = q_reg[DIV_STEPS];
    assign big  = qmag > {1'b1, {(DIV_STEPS-1){1'b0}}};

    always_comb begin
        if (neg_reg[DIV_STEPS]) begin
            if (ovf_reg[DIV_STEPS] || big) begin
                quot_next = T_NEG_INF;
            end else begin
                quot_next = -$signed(qmag);
            end
        end else begin
            if (ovf_reg[DIV_STEPS] || qmag[DIV_STEPS-1]) begin
                quot_next = T_POS_INF;
            end else begin
                quot_next = $signed(qmag);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {op.mag, {FRAC_W{1'b0}}};
            q_reg[0]   <= '0;
            den_reg[0] <= op.den;
            neg_reg[0] <= op.neg;
            ovf_reg[0] <= ovf_next;
            for (int s = 0; s < DIV_STEPS; s++) begin
                rem_reg[s+1] <= rem_next[s];
                q_reg[s+1]   <= q_next[s];
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== src/rbst_axis.sv =====
// rbst_axis: one axis of the slab test, operand prep, two dividers, parallel-ray handling
// depends on rbst_pkg and rbst_div
`timescale 1ns / 1ps
`default_nettype none

module rbst_axis import rbst_pkg::*; (
    input  wire                        aclk,
    input  wire                        en,
    input  wire  signed [COORD_W-1:0]  lo_b,
    input  wire  signed [COORD_W-1:0]  hi_b,
    input  wire  signed [COORD_W-1:0]  org,
    input  wire  signed [COORD_W-1:0]  dir,
    output logic signed [COORD_W-1:0]  lo,
    output logic signed [COORD_W-1:0]  hi
);

    div_op_t op_lo_reg, op_hi_reg, op_lo_next, op_hi_next;
    logic    zero_reg   [0:DIV_LAT];
    logic    inside_reg [0:DIV_LAT];
    logic    zero_next, inside_next;
    logic signed [COORD_W-1:0] q_lo, q_hi;

    always_comb begin
        logic signed [COORD_W-1:0] b_lo, b_hi;
        logic signed [DIFF_W-1:0]  d_lo, d_hi;
        logic [COORD_W-1:0]        dmag;
        // negative direction swaps which plane is entered first
        b_lo = dir[COORD_W-1] ? hi_b : lo_b;
        b_hi = dir[COORD_W-1] ? lo_b : hi_b;
        d_lo = {b_lo[COORD_W-1], b_lo} - {org[COORD_W-1], org};
        d_hi = {b_hi[COORD_W-1], b_hi} - {org[COORD_W-1], org};
        dmag = dir[COORD_W-1] ? COORD_W'(-dir) : COORD_W'(dir);
        op_lo_next.mag = d_lo[DIFF_W-1] ? DIFF_W'(-d_lo) : DIFF_W'(d_lo);
        op_lo_next.den = dmag;
        op_lo_next.neg = d_lo[DIFF_W-1] ^ dir[COORD_W-1];
        op_hi_next.mag = d_hi[DIFF_W-1] ? DIFF_W'(-d_hi) : DIFF_W'(d_hi);
        op_hi_next.den = dmag;
        op_hi_next.neg = d_hi[DIFF_W-1] ^ dir[COORD_W-1];
        zero_next      = (dir == '0);
        inside_next    = (org >= lo_b) && (org <= hi_b);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_lo_reg     <= op_lo_next;
            op_hi_reg     <= op_hi_next;
            zero_reg[0]   <= zero_next;
            inside_reg[0] <= inside_next;
            for (int s = 0; s < DIV_LAT; s++) begin
                zero_reg[s+1]   <= zero_reg[s];
                inside_reg[s+1] <= inside_reg[s];
            end
        end
    end

    rbst_div u_div_lo (.aclk(aclk), .en(en), .op(op_lo_reg), .quot(q_lo));
    rbst_div u_div_hi (.aclk(aclk), .en(en), .op(op_hi_reg), .quot(q_hi));

    // parallel ray: whole line or nothing, depending on origin in slab
    always_comb begin
        if (zero_reg[DIV_LAT]) begin
            lo = inside_reg[DIV_LAT] ? T_NEG_INF : T_POS_INF;
            hi = inside_reg[DIV_LAT] ? T_POS_INF : T_NEG_INF;
        end else begin
            lo = q_lo;
            hi = q_hi;
        end
    end

endmodule

`default_nettype wire

// ===== src/ray_box_slab_test_top.sv =====
// ray_box_slab_test_top: ray versus axis-aligned box slab test, q16.16 fixed point
// depends on rbst_pkg, rbst_axis (which uses rbst_div)
`timescale 1ns / 1ps
`default_nettype none

// One ray per transaction in, one result per transaction out, in order. The box corners
// sit in six registers written over the cfg port (index 0..5: min x/y/z, max x/y/z);
// writes to other indexes are dropped and cfg_ready is always high. Each of the six
// slab distances comes from its own pipelined restoring divider that resolves one
// quotient bit per stage, so while the output buffer is not full a new ray can enter
// every cycle and the block sustains one ray per clock. From input transaction to
// m_valid a ray passes one operand prep stage, 34 divider stages (overflow check,
// 32 quotient bits, saturate), one interval merge stage, one hit stage and the output
// buffer. The whole pipeline moves together; a two-entry output buffer holds results
// while m_ready is low, and s_ready drops only when that buffer is full.

module ray_box_slab_test_top import rbst_pkg::*; (
    input  wire                  aclk,
    input  wire                  aresetn,
    // ray input
    input  wire                  s_valid,
    output logic                 s_ready,
    input  rbst_in_t             s_data,
    // result output
    output logic                 m_valid,
    input  wire                  m_ready,
    output rbst_out_t            m_data,
    // box registers
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [COORD_W-1:0]    cfg_data
);

    // box corner registers
    logic signed [COORD_W-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [COORD_W-1:0] max_x_reg, max_y_reg, max_z_reg;

    // global pipeline advance; valid bits and limit travel beside the axis units
    logic                 en;
    logic                 vld_reg   [0:AX_LAT-1];
    logic [LIMIT_W-1:0]   limit_reg [0:AX_LAT-1];

    logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;

    // merge stage
    logic                      mrg_vld_reg;
    logic signed [COORD_W-1:0] mrg_enter_reg, mrg_exit_reg;
    logic [LIMIT_W-1:0]        mrg_limit_reg;
    logic signed [COORD_W-1:0] enter_next, exit_next;

    // hit stage
    logic                      hit_vld_reg;
    rbst_out_t                 hit_reg, hit_next;

    // output buffer
    rbst_out_t   buf_reg [0:1];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;

    // config writes, taken every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            min_z_reg <= '0;
            max_x_reg <= '0;
            max_y_reg <= '0;
            max_z_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_X: min_x_reg <= cfg_data;
                CFG_MIN_Y: min_y_reg <= cfg_data;
                CFG_MIN_Z: min_z_reg <= cfg_data;
                CFG_MAX_X: max_x_reg <= cfg_data;
                CFG_MAX_Y: max_y_reg <= cfg_data;
                CFG_MAX_Z: max_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stall only on a full output buffer, registered so ready has no path from m_ready
    assign en      = (cnt_reg != 2'd2);
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < AX_LAT; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int s = 1; s < AX_LAT; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            limit_reg[0] <= s_data.dist_limit;
            for (int s = 1; s < AX_LAT; s++) begin
                limit_reg[s] <= limit_reg[s-1];
            end
        end
    end

    // per-axis slab distances, all three axes in lock step
    rbst_axis u_axis_x (
        .aclk(aclk), .en(en), .lo_b(min_x_reg), .hi_b(max_x_reg),
        .org(s_data.origin_x), .dir(s_data.dir_x), .lo(lo_x), .hi(hi_x)
    );
    rbst_axis u_axis_y (
        .aclk(aclk), .en(en), .lo_b(min_y_reg), .hi_b(max_y_reg),
        .org(s_data.origin_y), .dir(s_data.dir_y), .lo(lo_y), .hi(hi_y)
    );
    rbst_axis u_axis_z (
        .aclk(aclk), .en(en), .lo_b(min_z_reg), .hi_b(max_z_reg),
        .org(s_data.origin_z), .dir(s_data.dir_z), .lo(lo_z), .hi(hi_z)
    );

    // entry is the latest lower plane, exit the earliest upper plane
    always_comb begin
        logic signed [COORD_W-1:0] e_xy, x_xy;
        e_xy       = (lo_y > lo_x) ? lo_y : lo_x;
        enter_next = (lo_z > e_xy) ? lo_z : e_xy;
        x_xy       = (hi_y < hi_x) ? hi_y : hi_x;
        exit_next  = (hi_z < x_xy) ? hi_z : x_xy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mrg_vld_reg <= 1'b0;
        end else if (en) begin
            mrg_vld_reg <= vld_reg[AX_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mrg_enter_reg <= enter_next;
            mrg_exit_reg  <= exit_next;
            mrg_limit_reg <= limit_reg[AX_LAT-1];
        end
    end

    // hit: exit beyond max(entry, 0) and entry short of the limit
    always_comb begin
        logic signed [COORD_W-1:0] floor0;
        floor0            = (mrg_enter_reg > 0) ? mrg_enter_reg : '0;
        hit_next.t_enter  = mrg_enter_reg;
        hit_next.t_exit   = mrg_exit_reg;
        hit_next.hit      = (mrg_exit_reg > floor0) &&
                            (mrg_enter_reg < $signed({1'b0, mrg_limit_reg}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_vld_reg <= 1'b0;
        end else if (en) begin
            hit_vld_reg <= mrg_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg <= hit_next;
        end
    end

    // two-entry output buffer
    assign push    = en && hit_vld_reg;
    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = buf_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= hit_reg;
        end
    end

    // buffer never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    // a reported hit has a nonempty interval ahead of the origin
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit |-> (m_data.t_exit > m_data.t_enter) && (m_data.t_exit > 0))
        else $error("hit with empty or past interval");

    // a stalled pipeline keeps its hit stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(hit_vld_reg) && $stable(hit_reg))
        else $error("hit stage changed during stall");

    // a full buffer with no transaction out keeps the input stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 && !m_ready |=> !s_ready)
        else $error("input taken while output buffer full");

endmodule

`default_nettype wire

// ===== tb/ray_box_slab_test_top_tb.sv =====
// ray_box_slab_test_top_tb: self-checking bench for the ray/box slab test
// depends on rbst_pkg and ray_box_slab_test_top; predicts each result and compares
`timescale 1ns / 1ps
`default_nettype none

// box registers plus expected results, in transaction order
class slab_scoreboard;
    int        box_lo[3];
    int        box_hi[3];
    rbst_pkg::rbst_out_t hits_due[$];
    int        errors;

    function new();
        foreach (box_lo[i]) begin
            box_lo[i] = 0;
            box_hi[i] = 0;
        end
        errors = 0;
    endfunction

    // out-of-range indexes are dropped like in the block
    function void set_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            rbst_pkg::CFG_MIN_X: box_lo[0] = val;
            rbst_pkg::CFG_MIN_Y: box_lo[1] = val;
            rbst_pkg::CFG_MIN_Z: box_lo[2] = val;
            rbst_pkg::CFG_MAX_X: box_hi[0] = val;
            rbst_pkg::CFG_MAX_Y: box_hi[1] = val;
            rbst_pkg::CFG_MAX_Z: box_hi[2] = val;
            default: ;
        endcase
    endfunction

    function longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // (bound - origin) * 2^16 / dir, truncated toward zero, then saturated
    function longint plane_dist(int bound, int org, int d);
        longint num;
        num = (longint'(bound) - longint'(org)) * 64'sd65536;
        return clip32(num / longint'(d));
    endfunction

    function void axis_span(int lo_b, int hi_b, int org, int d,
                            output longint lo, output longint hi);
        if (d == 0) begin
            if (org >= lo_b && org <= hi_b) begin
                lo = -64'sd2147483648;
                hi = 64'sd2147483647;
            end else begin
                lo = 64'sd2147483647;
                hi = -64'sd2147483648;
            end
        end else if (d > 0) begin
            lo = plane_dist(lo_b, org, d);
            hi = plane_dist(hi_b, org, d);
        end else begin
            lo = plane_dist(hi_b, org, d);
            hi = plane_dist(lo_b, org, d);
        end
    endfunction

    function void note_ray(rbst_pkg::rbst_in_t r);
        int                  org[3];
        int                  dir[3];
        longint              enter, leave, lo, hi, floor0;
        rbst_pkg::rbst_out_t res;
        org = '{r.origin_x, r.origin_y, r.origin_z};
        dir = '{r.dir_x, r.dir_y, r.dir_z};
        enter = -64'sd2147483648;
        leave = 64'sd2147483647;
        for (int a = 0; a < 3; a++) begin
            axis_span(box_lo[a], box_hi[a], org[a], dir[a], lo, hi);
            if (lo > enter) enter = lo;
            if (hi < leave) leave = hi;
        end
        floor0 = enter > 0 ? enter : 0;
        res.hit     = (leave > floor0) && (enter < longint'({1'b0, r.dist_limit}));
        res.t_enter = enter[31:0];
        res.t_exit  = leave[31:0];
        hits_due.push_back(res);
    endfunction

    function void check_result(rbst_pkg::rbst_out_t got);
        rbst_pkg::rbst_out_t want;
        if (hits_due.size() == 0) begin
            $error("result with nothing outstanding: %p", got);
            errors++;
            return;
        end
        want = hits_due.pop_front();
        if (got.hit !== want.hit) begin
            $error("hit: expected %0d actual %0d", want.hit, got.hit);
            errors++;
        end
        if (got.t_enter !== want.t_enter) begin
            $error("t_enter: expected %0d actual %0d", want.t_enter, got.t_enter);
            errors++;
        end
        if (got.t_exit !== want.t_exit) begin
            $error("t_exit: expected %0d actual %0d", want.t_exit, got.t_exit);
            errors++;
        end
    endfunction
endclass

module ray_box_slab_test_top_tb;
    import rbst_pkg::*;

    localparam int          ONE        = 1 << FRAC_W;     // 1.0 in q16.16
    localparam int          QUIET_MAX  = 5000;            // idle cycles before timeout
    localparam int          DRAIN_WAIT = AX_LAT + 10;     // pipeline depth plus margin
    localparam int          HOLD_LEN   = 300;             // long receiver hold-off
    localparam logic [2:0]  CFG_SPARE_A = 3'd6;           // unused register indexes
    localparam logic [2:0]  CFG_SPARE_B = 3'd7;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    rbst_in_t   s_data;
    logic       m_valid;
    logic       m_ready;
    rbst_out_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    slab_scoreboard sb = new();

    int gap_pct;        // sender idle chance, varies over the run
    int stall_pct;      // receiver stall chance
    int results_seen;
    bit hold_done;

    ray_box_slab_test_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // idle pressure is redrawn over the run, sometimes zero for clean stretches
    initial begin
        gap_pct   = 0;
        stall_pct = 0;
        forever begin
            repeat (256) @(negedge aclk);
            case ($urandom_range(0, 3))
                0: gap_pct = 0;
                1: gap_pct = 10;
                2: gap_pct = 30;
                default: gap_pct = 60;
            endcase
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 10;
                2: stall_pct = 30;
                default: stall_pct = 60;
            endcase
        end
    end

    // gap length: mostly short, now and then long
    function automatic int idle_len(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    // result side: random stalls, plus one long hold-off so the pipe fills
    initial begin
        int n;
        m_ready   = 1'b0;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= 400) begin
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                hold_done = 1'b1;
                m_ready <= 1'b1;
            end else begin
                n = idle_len(stall_pct);
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(negedge aclk);
                end
                m_ready <= 1'b1;
            end
        end
    end

    // compare every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
            results_seen <= results_seen + 1;
        end
    end

    // watchdog: cycles without any transaction on any channel
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // one ray transaction; called at a falling edge, returns at a falling edge
    task automatic send_ray(input rbst_in_t r);
        int n;
        n = idle_len(gap_pct);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        sb.note_ray(r);
        @(negedge aclk);
    endtask

    // one register transaction; cfg_valid is lowered by the caller
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
    endtask

    // wait for an empty pipe, then load a new box
    task automatic load_box(input int lx, input int ly, input int lz,
                            input int hx, input int hy, input int hz);
        s_valid <= 1'b0;
        wait (sb.hits_due.size() == 0);
        repeat (DRAIN_WAIT) @(negedge aclk);
        write_reg(CFG_MIN_X, lx);
        write_reg(CFG_MIN_Y, ly);
        write_reg(CFG_MIN_Z, lz);
        write_reg(CFG_MAX_X, hx);
        write_reg(CFG_MAX_Y, hy);
        write_reg(CFG_MAX_Z, hz);
        // dropped writes to the spare indexes
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        cfg_valid <= 1'b0;
    endtask

    function automatic rbst_in_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                          logic [LIMIT_W-1:0] lim);
        rbst_in_t r;
        r.origin_x   = ox;
        r.origin_y   = oy;
        r.origin_z   = oz;
        r.dir_x      = dx;
        r.dir_y      = dy;
        r.dir_z      = dz;
        r.dist_limit = lim;
        return r;
    endfunction

    // coordinate: full range, extremes, or near the box scale
    function automatic int pick_coord();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return T_POS_INF;
            3: return T_NEG_INF;
            4: return 0;
            default: return int'($urandom_range(0, 32 * ONE)) - 16 * ONE;
        endcase
    endfunction

    function automatic int pick_dir();
        case ($urandom_range(0, 11))
            0: return 0;
            1: return 1;
            2: return -1;
            3: return T_POS_INF;
            4: return T_NEG_INF;
            5, 6: return $urandom;
            default: return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default: return $urandom_range(0, 64 * ONE);
        endcase
    endfunction

    // ray aimed roughly at the box centre from a random origin
    function automatic rbst_in_t aimed_ray();
        int     org[3];
        int     dir[3];
        longint ctr;
        longint d;
        int     sh;
        sh = $urandom_range(0, 6);
        for (int a = 0; a < 3; a++) begin
            org[a] = pick_coord();
            ctr    = (longint'(sb.box_lo[a]) + longint'(sb.box_hi[a])) >>> 1;
            ctr    = ctr + longint'(int'($urandom_range(0, 2 * ONE)) - ONE);
            d      = sb.clip32((ctr - longint'(org[a])) >>> sh);
            dir[a] = d[31:0];
        end
        return make_ray(org[0], org[1], org[2], dir[0], dir[1], dir[2], pick_limit());
    endfunction

    task automatic random_rays(input int count);
        repeat (count) begin
            if ($urandom_range(0, 3) != 0)
                send_ray(aimed_ray());
            else
                send_ray(make_ray(pick_coord(), pick_coord(), pick_coord(),
                                  pick_dir(), pick_dir(), pick_dir(), pick_limit()));
        end
    endtask

    task automatic random_box();
        int a, b;
        int lo[3];
        int hi[3];
        for (int i = 0; i < 3; i++) begin
            a = pick_coord();
            b = pick_coord();
            lo[i] = a < b ? a : b;
            hi[i] = a < b ? b : a;
        end
        load_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endtask

    initial begin
        results_seen = 0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset box is a single point at the origin
        send_ray(make_ray(-ONE, 0, 0, ONE, 0, 0, '1));
        send_ray(make_ray(0, 0, 0, 0, 0, 0, '1));
        send_ray(make_ray(ONE, 0, 0, 0, 0, 0, '1));

        // unit-ish box around the origin
        load_box(-2 * ONE, -2 * ONE, -2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE);
        send_ray(make_ray(-8 * ONE, 0, 0, ONE, 0, 0, '1));          // straight hit, parallel y/z inside
        send_ray(make_ray(-8 * ONE, 5 * ONE, 0, ONE, 0, 0, '1));    // parallel axis outside slab
        send_ray(make_ray(8 * ONE, 0, 0, -ONE, 0, 0, '1));          // negative direction
        send_ray(make_ray(0, 0, 0, ONE, ONE, ONE, '1));             // origin inside box
        send_ray(make_ray(8 * ONE, 0, 0, ONE, 0, 0, '1));           // box behind ray
        send_ray(make_ray(-8 * ONE, 0, 0, ONE, 0, 0, '0));          // zero limit
        send_ray(make_ray(-8 * ONE, 0, 0, ONE, 0, 0, 6 * ONE));     // entry equals limit
        send_ray(make_ray(-8 * ONE, 0, 0, 1, 0, 0, '1));            // tiny dir, quotient saturates
        send_ray(make_ray(-8 * ONE, 0, 0, -1, 0, 0, '1));
        send_ray(make_ray(T_NEG_INF, T_NEG_INF, T_NEG_INF, T_POS_INF, T_POS_INF,
                          T_POS_INF, '1));
        send_ray(make_ray(T_POS_INF, T_POS_INF, T_POS_INF, T_NEG_INF, T_NEG_INF,
                          T_NEG_INF, '1));
        send_ray(make_ray(-2 * ONE, 2 * ONE, 0, ONE, 0, 0, '1));    // parallel, on the boundary
        send_ray(make_ray(0, 0, 0, 0, 0, 0, '0));                   // all parallel inside
        send_ray(make_ray(-4 * ONE, -4 * ONE, 0, ONE, -ONE, 0, '1));// y runs away from the box, a miss
        random_rays(280);

        // whole coordinate range
        load_box(T_NEG_INF, T_NEG_INF, T_NEG_INF, T_POS_INF, T_POS_INF, T_POS_INF);
        send_ray(make_ray(T_NEG_INF, 0, T_POS_INF, 1, 0, -1, '1));
        send_ray(make_ray(0, 0, 0, T_NEG_INF, T_POS_INF, 0, '1));
        random_rays(280);

        // inverted box: min above max
        load_box(3 * ONE, 3 * ONE, 3 * ONE, -3 * ONE, -3 * ONE, -3 * ONE);
        send_ray(make_ray(0, 0, 0, 0, 0, 0, '1));
        send_ray(make_ray(-8 * ONE, 0, 0, ONE, 0, 0, '1));
        random_rays(280);

        // flat box with zero thickness in z
        load_box(-ONE, -5 * ONE, 0, 7 * ONE, ONE, 0);
        random_rays(280);

        random_box();
        random_rays(150);
        random_box();
        random_rays(150);

        s_valid <= 1'b0;
        wait (sb.hits_due.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.errors == 0 && sb.hits_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/rbst_pkg.sv
src/rbst_div.sv
src/rbst_axis.sv
src/ray_box_slab_test_top.sv
tb/ray_box_slab_test_top_tb.sv
